### hw/rtl/utf8_stream_decoder_top_assert.svh
// Assertion macros for the UTF-8 stream decoder back end.
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, clocked on clock, off during reset.
`define U8SD_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("u8sd assertion failed");
// Next-cycle implication, clocked on clock, off during reset.
`define U8SD_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("u8sd assertion failed");
`else
`define U8SD_ASSERT_IMP(label, ante, cons)
`define U8SD_ASSERT_NXT(label, ante, cons)
`endif

`endif

### hw/rtl/u8sd_pkg.sv
// Types, constants and lead-byte decode shared by the UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

   localparam int COUNT_BITS  = 32;
   localparam int CHAR_CNT_W  = 32;
   localparam int CP_W        = 21;
   localparam int LEN_W       = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Sequence lengths
   localparam logic [LEN_W-1:0] LEN_ZERO = 3'd0;
   localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

   // Continuation bytes still expected
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   typedef enum logic [2:0] {
      LEAD_ASCII,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_BAD
   } lead_kind_type;

   // One decoded event passed from the front end to the back end
   typedef struct packed {
      logic                  is_error;
      logic                  last;
      logic [LEN_W-1:0]      seq_length;
      logic [CP_W-1:0]       unicode_value;
   } event_type;

   // Classify a byte seen where a lead byte is expected
   function automatic lead_kind_type classify_lead(input logic [7:0] b);
      lead_kind_type kind;
      kind = LEAD_BAD;
      if (b[7] == 1'b0) begin
         kind = LEAD_ASCII;
      end else if ((b & 8'hE0) == 8'hC0) begin
         kind = LEAD_TWO;
      end else if ((b & 8'hF0) == 8'hE0) begin
         kind = LEAD_THREE;
      end else if ((b & 8'hF8) == 8'hF0) begin
         kind = LEAD_FOUR;
      end
      return kind;
   endfunction

   function automatic logic is_continuation(input logic [7:0] b);
      return (b & 8'hC0) == 8'h80;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/u8sd_front.sv
// Front end: takes bytes, tracks open sequences and emits decode events.
`default_nettype none

module u8sd_front
   import u8sd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  data_byte,
   input  wire logic        end_of_buffer,
   output logic             ev_push,
   output event_type        ev_data
);

   logic [1:0]       pending_ff, pending_in;
   logic             err_ff, err_in;
   logic [CP_W-1:0]  partial_ff, partial_in;
   logic [LEN_W-1:0] size_ff, size_in;

   lead_kind_type    lead_kind;
   logic [CP_W-1:0]  merged;
   logic [1:0]       pending_dec;

   assign lead_kind   = classify_lead(data_byte);
   assign merged      = {partial_ff[CP_W-7:0], data_byte[5:0]};
   assign pending_dec = pending_ff - 2'd1;

   // Sequence tracking and event generation
   always_comb begin
      pending_in = pending_ff;
      err_in     = err_ff;
      partial_in = partial_ff;
      size_in    = size_ff;
      ev_push    = 1'b0;
      ev_data    = '{is_error: 1'b1, last: end_of_buffer, seq_length: LEN_ZERO,
                     unicode_value: '0};
      if (accept) begin
         if (err_ff) begin
            // dropping bytes until the buffer end
            if (end_of_buffer) begin
               ev_push = 1'b1;
               err_in  = 1'b0;
            end
         end else if (pending_ff == PEND_NONE) begin
            unique case (lead_kind)
               LEAD_ASCII: begin
                  ev_push = 1'b1;
                  ev_data = '{is_error: 1'b0, last: end_of_buffer, seq_length: LEN_ONE,
                              unicode_value: CP_W'(data_byte[6:0])};
               end
               LEAD_TWO: begin
                  partial_in = CP_W'(data_byte[4:0]);
                  size_in    = LEN_TWO;
                  pending_in = PEND_ONE;
               end
               LEAD_THREE: begin
                  partial_in = CP_W'(data_byte[3:0]);
                  size_in    = LEN_THREE;
                  pending_in = PEND_TWO;
               end
               LEAD_FOUR: begin
                  partial_in = CP_W'(data_byte[2:0]);
                  size_in    = LEN_FOUR;
                  pending_in = PEND_THREE;
               end
               default: begin
                  ev_push = 1'b1;
                  err_in  = !end_of_buffer;
               end
            endcase
            // truncated right after the lead byte
            if (end_of_buffer && lead_kind != LEAD_ASCII && lead_kind != LEAD_BAD) begin
               ev_push    = 1'b1;
               pending_in = PEND_NONE;
            end
         end else if (!is_continuation(data_byte)) begin
            ev_push    = 1'b1;
            pending_in = PEND_NONE;
            err_in     = !end_of_buffer;
         end else begin
            partial_in = merged;
            pending_in = pending_dec;
            if (pending_dec == PEND_NONE) begin
               ev_push = 1'b1;
               ev_data = '{is_error: 1'b0, last: end_of_buffer, seq_length: size_ff,
                           unicode_value: merged};
            end else if (end_of_buffer) begin
               ev_push    = 1'b1;
               pending_in = PEND_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
         err_ff     <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         err_ff     <= err_in;
      end
      partial_ff <= partial_in;
      size_ff    <= size_in;
   end

endmodule

`default_nettype wire

### hw/rtl/u8sd_queue.sv
// Short event queue between the front end and the back end.
`default_nettype none

module u8sd_queue
   import u8sd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire event_type push_data,
   output logic           full,
   input  wire logic      pop,
   output logic           empty,
   output event_type      head
);

   event_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/u8sd_back.sv
// Back end: keeps the running count and holds the result register.
`default_nettype none
`include "utf8_stream_decoder_top_assert.svh"

module u8sd_back
   import u8sd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire event_type         q_head,
   output logic                   q_pop,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output logic [CP_W-1:0]        rsp_unicode_value,
   output logic [LEN_W-1:0]       rsp_seq_length,
   output logic                   rsp_decode_error,
   output logic                   rsp_buffer_last,
   output logic [CHAR_CNT_W-1:0]  rsp_char_count
);

   localparam int WIDE_W = (COUNT_BITS > CHAR_CNT_W) ? COUNT_BITS : CHAR_CNT_W;

   logic                  valid_ff, valid_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   event_type             ev_ff;
   logic [CHAR_CNT_W-1:0] char_ff, char_in;
   logic [COUNT_BITS-1:0] count_inc;
   logic [WIDE_W-1:0]     count_wide;
   logic                  load;

   assign load       = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop      = load;
   assign count_inc  = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign count_wide = WIDE_W'(count_inc);

   // Count update and reported count for the event being loaded
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      char_in  = char_ff;
      if (rsp_pop && valid_ff) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         if (q_head.is_error) begin
            count_in = '0;
            char_in  = '0;
         end else begin
            count_in = q_head.last ? '0 : count_inc;
            char_in  = (count_wide > WIDE_W'({CHAR_CNT_W{1'b1}})) ? '1
                                                                    : count_wide[CHAR_CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      if (load) begin
         ev_ff   <= q_head;
         char_ff <= char_in;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_unicode_value = ev_ff.unicode_value;
   assign rsp_seq_length    = ev_ff.seq_length;
   assign rsp_decode_error  = ev_ff.is_error;
   assign rsp_buffer_last   = ev_ff.last;
   assign rsp_char_count    = char_ff;

   // Error results carry no code point, length or count
   `U8SD_ASSERT_IMP(a_error_zero, valid_ff && ev_ff.is_error,
      ev_ff.unicode_value == '0 && ev_ff.seq_length == LEN_ZERO && char_ff == '0)
   // Good results have a real length and a nonzero count
   `U8SD_ASSERT_IMP(a_good_shape, valid_ff && !ev_ff.is_error,
      ev_ff.seq_length >= LEN_ONE && ev_ff.seq_length <= LEN_FOUR && char_ff != '0)
   // The count restarts after every buffer end
   `U8SD_ASSERT_NXT(a_count_clear, load && q_head.last, count_ff == '0)
   // A good mid-buffer event bumps the count by one below saturation
   `U8SD_ASSERT_NXT(a_count_step,
      load && !q_head.is_error && !q_head.last && count_ff != '1,
      count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

### hw/rtl/utf8_stream_decoder_top.sv
// UTF-8 stream decoder: bytes in, one code point result per sequence out.
//
// Input channel: push req_data_byte with req_end_of_buffer on the buffer's
// final byte; a byte is taken on a clock edge with req_push high and
// req_full low. Result channel: while rsp_empty is low the oldest result
// is on the rsp_ ports; it is taken on an edge with rsp_pop high.
// A byte that completes a sequence, or ends a buffer, or breaks a sequence,
// gives one result; other bytes give none. After an error bytes are dropped
// until the buffer end, which gives a second error result.
// Throughput: one byte per cycle sustained while req_full is low. The event
// for a byte enters the queue at the edge that takes the byte; the queue head
// loads the result register once that register is empty or being popped, and
// the result is on the rsp_ ports from then until an edge with rsp_pop high.
// Stalls: the result register and a four-entry event queue decouple the
// sides; req_full rises only when the queue is full behind a stalled rsp_pop.
// Reset (synchronous, active high) empties both channels and clears the
// sequence state, error latch and running count; no init time is needed.
`default_nettype none

module utf8_stream_decoder_top
   import u8sd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_end_of_buffer,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [CP_W-1:0]        rsp_unicode_value,
   output logic [LEN_W-1:0]       rsp_seq_length,
   output logic                   rsp_decode_error,
   output logic                   rsp_buffer_last,
   output logic [CHAR_CNT_W-1:0]  rsp_char_count
);

   logic      accept;
   logic      ev_push;
   event_type ev_data;
   logic      q_full, q_empty, q_pop;
   event_type q_head;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   u8sd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_buffer (req_end_of_buffer),
      .ev_push       (ev_push),
      .ev_data       (ev_data)
   );

   u8sd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   u8sd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_unicode_value (rsp_unicode_value),
      .rsp_seq_length    (rsp_seq_length),
      .rsp_decode_error  (rsp_decode_error),
      .rsp_buffer_last   (rsp_buffer_last),
      .rsp_char_count    (rsp_char_count)
   );

endmodule

`default_nettype wire

### tb/tb_utf8_stream_decoder_top.sv
// Self-checking testbench for the UTF-8 stream decoder top level.
`default_nettype none

module tb_utf8_stream_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;
   import u8sd_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 4;
   localparam int ITEMS_PER_RUN = 1900;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int PRINT_LIMIT   = 20;

   // One result transaction as seen on the rsp_ ports
   typedef struct {
      logic [CP_W-1:0]       unicode_value;
      logic [LEN_W-1:0]      seq_length;
      logic                  decode_error;
      logic                  buffer_last;
      logic [CHAR_CNT_W-1:0] char_count;
   } utf8_result_type;

   // Decoder model plus the queue of results it predicts
   class utf8_scoreboard_type;
      utf8_result_type  pending_results[$];
      logic [1:0]       cont_left;
      logic [CP_W-1:0]  cp_accum;
      logic [LEN_W-1:0] seq_len;
      logic [COUNT_BITS-1:0] point_count;
      logic             dropping;
      int mismatches;
      int bytes_decoded;
      int buffers_seen;
      int points_checked;
      int errors_checked;

      function new();
         cont_left   = PEND_NONE;
         cp_accum    = '0;
         seq_len     = LEN_ZERO;
         point_count = '0;
         dropping    = 1'b0;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function lead_kind_type lead_of(input logic [7:0] data);
         if (!data[7])
            return LEAD_ASCII;
         if (data[7:5] == 3'b110)
            return LEAD_TWO;
         if (data[7:4] == 4'b1110)
            return LEAD_THREE;
         if (data[7:3] == 5'b11110)
            return LEAD_FOUR;
         return LEAD_BAD;
      endfunction

      function void clear_seq();
         cont_left = PEND_NONE;
         cp_accum  = '0;
         seq_len   = LEN_ZERO;
      endfunction

      function void predict_error(input logic eob);
         utf8_result_type r;
         clear_seq();
         point_count     = '0;
         dropping        = !eob;
         r.unicode_value = '0;
         r.seq_length    = LEN_ZERO;
         r.decode_error  = 1'b1;
         r.buffer_last   = eob;
         r.char_count    = '0;
         pending_results.push_back(r);
      endfunction

      function void predict_point(input logic eob);
         utf8_result_type r;
         logic [63:0]     wide;
         if (point_count != '1)
            point_count++;
         wide            = 64'(point_count);
         r.unicode_value = cp_accum;
         r.seq_length    = seq_len;
         r.decode_error  = 1'b0;
         r.buffer_last   = eob;
         r.char_count    = (wide > 64'hFFFF_FFFF) ? '1 : wide[CHAR_CNT_W-1:0];
         pending_results.push_back(r);
         clear_seq();
         if (eob)
            point_count = '0;
      endfunction

      // Advance the decoder by one accepted input transaction
      function void note_byte(input logic [7:0] data, input logic eob);
         if (eob)
            buffers_seen++;
         // dropping after an error: only the buffer end speaks
         if (dropping) begin
            if (eob)
               predict_error(1'b1);
            return;
         end
         bytes_decoded++;
         if (cont_left == PEND_NONE) begin
            case (lead_of(data))
               LEAD_ASCII: begin
                  cp_accum = CP_W'(data[6:0]);
                  seq_len  = LEN_ONE;
                  predict_point(eob);
                  return;
               end
               LEAD_TWO: begin
                  cp_accum  = CP_W'(data[4:0]);
                  seq_len   = LEN_TWO;
                  cont_left = PEND_ONE;
               end
               LEAD_THREE: begin
                  cp_accum  = CP_W'(data[3:0]);
                  seq_len   = LEN_THREE;
                  cont_left = PEND_TWO;
               end
               LEAD_FOUR: begin
                  cp_accum  = CP_W'(data[2:0]);
                  seq_len   = LEN_FOUR;
                  cont_left = PEND_THREE;
               end
               default: begin
                  predict_error(eob);
                  return;
               end
            endcase
            if (eob)
               predict_error(1'b1);
            return;
         end
         // inside a sequence: continuation expected
         if (data[7:6] != 2'b10) begin
            predict_error(eob);
            return;
         end
         cp_accum  = {cp_accum[CP_W-7:0], data[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == PEND_NONE)
            predict_point(eob);
         else if (eob)
            predict_error(1'b1);
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      // Compare one popped result with the oldest prediction
      task check_result(input utf8_result_type got);
         utf8_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result cp=%h err=%b",
                                      got.unicode_value, got.decode_error));
            return;
         end
         want = pending_results.pop_front();
         if (want.decode_error)
            errors_checked++;
         else
            points_checked++;
         if (got.unicode_value !== want.unicode_value)
            report_mismatch($sformatf("unicode_value %h, want %h",
                                      got.unicode_value, want.unicode_value));
         if (got.seq_length !== want.seq_length)
            report_mismatch($sformatf("seq_length %0d, want %0d",
                                      got.seq_length, want.seq_length));
         if (got.decode_error !== want.decode_error)
            report_mismatch($sformatf("decode_error %b, want %b",
                                      got.decode_error, want.decode_error));
         if (got.buffer_last !== want.buffer_last)
            report_mismatch($sformatf("buffer_last %b, want %b",
                                      got.buffer_last, want.buffer_last));
         if (got.char_count !== want.char_count)
            report_mismatch($sformatf("char_count %0d, want %0d",
                                      got.char_count, want.char_count));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  req_end_of_buffer = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [CP_W-1:0]       rsp_unicode_value;
   logic [LEN_W-1:0]      rsp_seq_length;
   logic                  rsp_decode_error;
   logic                  rsp_buffer_last;
   logic [CHAR_CNT_W-1:0] rsp_char_count;

   utf8_scoreboard_type sb = new();
   int  send_idle = 0;
   int  recv_idle = 0;
   logic hold_request = 1'b0;
   int  quiet_cycles = 0;

   utf8_stream_decoder_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_unicode_value (rsp_unicode_value),
      .rsp_seq_length    (rsp_seq_length),
      .rsp_decode_error  (rsp_decode_error),
      .rsp_buffer_last   (rsp_buffer_last),
      .rsp_char_count    (rsp_char_count)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Result side: random pops, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_pop <= 1'b0;
            hold_left--;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // Check every result transaction
   always @(posedge clock) begin
      utf8_result_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.unicode_value = rsp_unicode_value;
         got.seq_length    = rsp_seq_length;
         got.decode_error  = rsp_decode_error;
         got.buffer_last   = rsp_buffer_last;
         got.char_count    = rsp_char_count;
         sb.check_result(got);
      end
   end

   // Watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic eob);
      while ($urandom_range(99) < send_idle) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push          <= 1'b1;
      req_data_byte     <= data;
      req_end_of_buffer <= eob;
      do
         @(posedge clock);
      while (req_full);
      sb.note_byte(data, eob);
   endtask

   function automatic logic [7:0] cont_byte();
      return {2'b10, 6'($urandom_range(63))};
   endfunction

   // Mostly well-formed buffers with random content; some faults and noise
   task automatic send_random_buffer();
      logic [7:0] buf_q[$];
      logic [7:0] seq_q[$];
      logic [7:0] bad;
      int nseq;
      int len;
      int fault;
      int k;
      if ($urandom_range(99) < 5) begin
         repeat ($urandom_range(1, 8))
            buf_q.push_back(8'($urandom_range(255)));
      end else begin
         nseq = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         for (int s = 0; s < nseq; s++) begin
            len = $urandom_range(1, 4);
            seq_q.delete();
            case (len)
               1: seq_q.push_back({1'b0, 7'($urandom_range(127))});
               2: seq_q.push_back({3'b110, 5'($urandom_range(31))});
               3: seq_q.push_back({4'b1110, 4'($urandom_range(15))});
               default: seq_q.push_back({5'b11110, 3'($urandom_range(7))});
            endcase
            for (int c = 1; c < len; c++)
               seq_q.push_back(cont_byte());
            fault = $urandom_range(99);
            if (fault < 4) begin
               // stray continuation or 11111xxx where a lead belongs
               bad = ($urandom_range(1) == 1) ? cont_byte()
                                               : {5'b11111, 3'($urandom_range(7))};
               buf_q.push_back(bad);
            end else if (fault < 8 && len > 1) begin
               // broken continuation
               k   = $urandom_range(1, len - 1);
               bad = 8'($urandom_range(255));
               if (bad[7:6] == 2'b10)
                  bad[6] = 1'b1;
               seq_q[k] = bad;
            end else if (fault < 11 && len > 1) begin
               // buffer ends inside the sequence
               k = $urandom_range(1, len - 1);
               while (seq_q.size() > k)
                  void'(seq_q.pop_back());
               foreach (seq_q[i])
                  buf_q.push_back(seq_q[i]);
               break;
            end
            foreach (seq_q[i])
               buf_q.push_back(seq_q[i]);
         end
      end
      foreach (buf_q[i])
         send_byte(buf_q[i], i == buf_q.size() - 1);
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int s_idle, input int r_idle, input int items,
                            input bit hold);
      int start;
      bit held;
      send_idle = s_idle;
      recv_idle = r_idle;
      start     = sb.bytes_decoded;
      held      = 1'b0;
      while (sb.bytes_decoded - start < items) begin
         if (hold && !held && sb.bytes_decoded - start > items / 3) begin
            hold_request = 1'b1;
            held         = 1'b1;
         end
         send_random_buffer();
      end
      // sender pauses until all results are back
      @(negedge clock);
      req_push <= 1'b0;
      wait_drained();
   endtask

   // Directed bytes: {end_of_buffer, data}
   logic [8:0] directed_q[$] = '{
      // ASCII extremes, two-byte extremes
      9'h000, 9'h07F, 9'h0C0, 9'h080, 9'h0DF, 9'h0BF,
      // three-byte low, four-byte high ending the buffer
      9'h0E0, 9'h080, 9'h080, 9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
      // bad lead (continuation form), then dropped bytes to the end
      9'h080, 9'h041, 9'h141,
      // bad lead 11111xxx on the last byte
      9'h1FF,
      // bad continuation, dropped until end
      9'h0C3, 9'h041, 9'h100,
      // truncation on a lead and inside a sequence
      9'h1F0, 9'h0E2, 9'h182,
      // bad lead 0xF8 on the last byte
      9'h1F8
   };

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      send_idle = 26;
      recv_idle = 65;
      foreach (directed_q[i])
         send_byte(directed_q[i][7:0], directed_q[i][8]);

      run_phase(26, 65, ITEMS_PER_RUN / 3, 1'b1);
      run_phase(65, 26, ITEMS_PER_RUN / 3, 1'b0);
      run_phase(0, 0, ITEMS_PER_RUN / 3, 1'b1);

      $display("tb: %0d bytes decoded over %0d buffers, mixed idle and back-pressure",
               sb.bytes_decoded, sb.buffers_seen);
      $display("tb: %0d code points and %0d error results checked, %0d mismatches",
               sb.points_checked, sb.errors_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_front.sv
hw/rtl/u8sd_queue.sv
hw/rtl/u8sd_back.sv
hw/rtl/utf8_stream_decoder_top.sv
tb/tb_utf8_stream_decoder_top.sv
